### design/upm_pkg.sv
// Package for the RGBA8 alpha unpremultiply pipeline.
// Holds the channel types, pipeline word layout and the restoring divide step.
// No dependencies; every other design file uses it.
package upm_pkg;

  localparam int unsigned ChanW           = 8;
  localparam int unsigned NumCh           = 3;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned NumDivStages    = ChanW / DivBitsPerStage;
  // prep stage + divide stages + output register
  localparam int unsigned PipeDepth       = NumDivStages + 2;

  localparam int unsigned IdxRed   = 0;
  localparam int unsigned IdxGreen = 1;
  localparam int unsigned IdxBlue  = 2;

  localparam logic [ChanW-1:0] ChanMax  = 8'd255;
  localparam logic [ChanW-1:0] ChanZero = 8'd0;

  typedef logic [ChanW-1:0] chan_t;

  // Per-channel divider state: partial remainder, numerator bits not yet
  // consumed (MSB first), quotient bits so far, and the saturate flag.
  typedef struct packed {
    chan_t rem;
    chan_t num_lo;
    chan_t quot;
    logic  sat;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NumCh-1:0] lane;
    chan_t                 alpha;
    logic                  zero;
    logic                  last;
  } div_word_t;

  typedef struct packed {
    chan_t rem;
    logic  qbit;
  } div_step_t;

  // One restoring division step: shift in a numerator bit, subtract if it fits.
  function automatic div_step_t div_step(chan_t rem, logic nbit, chan_t den);
    logic [ChanW:0] trial;
    div_step_t      res;
    trial = {rem, nbit};
    if (trial >= {1'b0, den}) begin
      res.rem  = ChanW'(trial - {1'b0, den});
      res.qbit = 1'b1;
    end else begin
      res.rem  = trial[ChanW-1:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

### design/upm_if.sv
// Pixel channel interfaces for the alpha unpremultiply block.
// Depends on upm_pkg for the channel type.
interface upm_in_if;
  logic           valid;
  logic           ready;
  upm_pkg::chan_t red_in;
  upm_pkg::chan_t green_in;
  upm_pkg::chan_t blue_in;
  upm_pkg::chan_t alpha_in;
  logic           last_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, last_in,
                  input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, last_in,
                  output ready);
endinterface

interface upm_out_if;
  logic           valid;
  logic           ready;
  upm_pkg::chan_t red_out;
  upm_pkg::chan_t green_out;
  upm_pkg::chan_t blue_out;
  upm_pkg::chan_t alpha_out;
  logic           last_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, last_out,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, last_out,
                  output ready);
endinterface

### design/upm_prep.sv
// Input stage: forms the rounded numerator c*255 + alpha/2 per channel and
// the saturate / transparent flags. Depends on upm_pkg and upm_in_if.
module upm_prep (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  upm_in_if.sink                in_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output upm_pkg::div_word_t    data_o
);

  logic               valid_q;
  upm_pkg::div_word_t data_d, data_q;
  upm_pkg::chan_t     chan [upm_pkg::NumCh];

  assign chan[upm_pkg::IdxRed]   = in_i.red_in;
  assign chan[upm_pkg::IdxGreen] = in_i.green_in;
  assign chan[upm_pkg::IdxBlue]  = in_i.blue_in;

  always_comb begin
    logic [2*upm_pkg::ChanW-1:0] num;
    data_d       = '0;
    data_d.alpha = in_i.alpha_in;
    data_d.zero  = (in_i.alpha_in == upm_pkg::ChanZero);
    data_d.last  = in_i.last_in;
    for (int unsigned i = 0; i < upm_pkg::NumCh; i++) begin
      // c*255 = (c << 8) - c; max total 65152 fits in 16 bits
      num = {chan[i], upm_pkg::ChanZero}
          - {upm_pkg::ChanZero, chan[i]}
          + {upm_pkg::ChanZero, 1'b0, in_i.alpha_in[upm_pkg::ChanW-1:1]};
      // quotient fits in 8 bits only when the high half is below alpha,
      // which holds exactly when c <= alpha
      data_d.lane[i].rem    = num[2*upm_pkg::ChanW-1:upm_pkg::ChanW];
      data_d.lane[i].num_lo = num[upm_pkg::ChanW-1:0];
      data_d.lane[i].quot   = upm_pkg::ChanZero;
      data_d.lane[i].sat    = (chan[i] >= in_i.alpha_in);
    end
  end

  assign in_i.ready = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/upm_div_stage.sv
// One divider stage: two restoring division steps on all three channels.
// Depends on upm_pkg.
module upm_div_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  upm_pkg::div_word_t    data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output upm_pkg::div_word_t    data_o
);

  logic               valid_q;
  upm_pkg::div_word_t data_d, data_q;

  always_comb begin
    upm_pkg::div_step_t st;
    data_d = data_i;
    for (int unsigned i = 0; i < upm_pkg::NumCh; i++) begin
      for (int unsigned k = 0; k < upm_pkg::DivBitsPerStage; k++) begin
        st = upm_pkg::div_step(data_d.lane[i].rem,
                               data_d.lane[i].num_lo[upm_pkg::ChanW-1],
                               data_d.alpha);
        data_d.lane[i].rem    = st.rem;
        data_d.lane[i].num_lo = {data_d.lane[i].num_lo[upm_pkg::ChanW-2:0], 1'b0};
        data_d.lane[i].quot   = {data_d.lane[i].quot[upm_pkg::ChanW-2:0], st.qbit};
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/upm_out.sv
// Output register: applies saturation and the transparent-pixel rule, then
// drives the result channel. Depends on upm_pkg and upm_out_if.
module upm_out (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  upm_pkg::div_word_t    data_i,
  upm_out_if.source             out_o
);

  logic           valid_q;
  upm_pkg::chan_t chan_d [upm_pkg::NumCh];
  upm_pkg::chan_t chan_q [upm_pkg::NumCh];
  upm_pkg::chan_t alpha_d, alpha_q;
  logic           last_q;

  always_comb begin
    for (int unsigned i = 0; i < upm_pkg::NumCh; i++) begin
      if (data_i.zero) begin
        chan_d[i] = upm_pkg::ChanZero;
      end else if (data_i.lane[i].sat) begin
        chan_d[i] = upm_pkg::ChanMax;
      end else begin
        chan_d[i] = data_i.lane[i].quot;
      end
    end
    alpha_d = data_i.zero ? upm_pkg::ChanZero : data_i.alpha;
  end

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      chan_q  <= chan_d;
      alpha_q <= alpha_d;
      last_q  <= data_i.last;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.red_out   = chan_q[upm_pkg::IdxRed];
  assign out_o.green_out = chan_q[upm_pkg::IdxGreen];
  assign out_o.blue_out  = chan_q[upm_pkg::IdxBlue];
  assign out_o.alpha_out = alpha_q;
  assign out_o.last_out  = last_q;

endmodule

### design/rgba8_alpha_unpremultiply.sv
// RGBA8 alpha unpremultiply, top level.
// Channels: in_i takes one premultiplied pixel (red_in, green_in, blue_in,
// alpha_in, last_in) per transaction; out_o returns the straight-alpha pixel
// with the last flag carried alongside. Each color becomes
// (c*255 + alpha/2) / alpha, saturated at 255; alpha zero gives all zeros.
// Pipeline: one prep stage, four divider stages at two quotient bits each
// and one output register. Throughput, while out_o takes every result:
// one pixel per cycle; the 8-step restoring divide is spread
// over the four divider stages, so no unit is shared between pixels.
// Reset clears every stage valid bit; the pipeline comes up empty and ready.
// When the receiver stalls, the output holds its transaction and stages
// upstream keep filling any empty slots; in_i.ready drops only once every
// stage holds a pixel. Nothing is lost or repeated across a stall.
// Depends on upm_pkg, upm_if, upm_prep, upm_div_stage and upm_out.
module rgba8_alpha_unpremultiply (
  input  logic       clk_i,
  input  logic       rst_ni,
  upm_in_if.sink     in_i,
  upm_out_if.source  out_o
);

  logic               stg_valid [upm_pkg::NumDivStages+1];
  logic               stg_ready [upm_pkg::NumDivStages+1];
  upm_pkg::div_word_t stg_data  [upm_pkg::NumDivStages+1];

  upm_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .data_o  (stg_data[0])
  );

  for (genvar k = 0; k < upm_pkg::NumDivStages; k++) begin : g_div
    upm_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .data_i  (stg_data[k]),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .data_o  (stg_data[k+1])
    );
  end

  upm_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[upm_pkg::NumDivStages]),
    .ready_o (stg_ready[upm_pkg::NumDivStages]),
    .data_i  (stg_data[upm_pkg::NumDivStages]),
    .out_o   (out_o)
  );

endmodule

### design/upm_check.sv
// Port-level checker for the alpha unpremultiply block, bound to the top.
// Depends on upm_pkg for the pipeline depth.
module upm_check (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input upm_pkg::chan_t red_i,
  input upm_pkg::chan_t green_i,
  input upm_pkg::chan_t blue_i,
  input upm_pkg::chan_t alpha_i,
  input logic           last_i
);

  localparam int unsigned CntW = $clog2(upm_pkg::PipeDepth + 1);

  logic [CntW-1:0] occ_d, occ_q;

  // transactions inside the block: accepted but not yet delivered
  always_comb begin
    occ_d = occ_q;
    if (in_valid_i && in_ready_i) begin
      occ_d = occ_d + CntW'(1);
    end
    if (out_valid_i && out_ready_i) begin
      occ_d = occ_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({red_i, green_i, blue_i, alpha_i, last_i}))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> occ_q != '0)
    else $error("result shown with no pixel in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(upm_pkg::PipeDepth))
    else $error("more pixels in flight than pipeline stages");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled while output is free");

  a_transparent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && alpha_i == upm_pkg::ChanZero |->
      red_i == upm_pkg::ChanZero && green_i == upm_pkg::ChanZero &&
      blue_i == upm_pkg::ChanZero)
    else $error("transparent pixel with nonzero color");

endmodule

bind rgba8_alpha_unpremultiply upm_check u_upm_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .red_i       (out_o.red_out),
  .green_i     (out_o.green_out),
  .blue_i      (out_o.blue_out),
  .alpha_i     (out_o.alpha_out),
  .last_i      (out_o.last_out)
);
